// ===== src/rgbld_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbld_pkg
// Shared types and constants for the rgb left delta decoder.
// ----------------------------------------------------------------------------
package rgbld_pkg;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned COL_W   = 14;
    localparam int unsigned WIDTH_W = 15;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DATA_W  = 32;

    // delta codes carry a bias of half the byte range
    localparam logic [PIX_W-1:0] CODE_BIAS = 8'd128;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH = 15'd16384;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_IMAGE_WIDTH = 1'b0,
        REG_DELTA_MODE  = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             frame_start;
    } pixel_code_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             row_end;
    } pixel_out_t;

    // last column index for a programmed width (0 acts as 1, clamp to max)
    function automatic logic [COL_W-1:0] last_column(input logic [WIDTH_W-1:0] width);
        logic [WIDTH_W-1:0] w;
        begin
            w = width;
            if (w == '0) begin
                w = WIDTH_W'(1);
            end else if (w > MAX_WIDTH) begin
                w = MAX_WIDTH;
            end
            last_column = COL_W'(w - WIDTH_W'(1));
        end
    endfunction

endpackage

// ===== src/rgb_left_delta_decoder.sv =====
// ----------------------------------------------------------------------------
// rgb_left_delta_decoder
// Left-predicted RGB delta decoder with optional green reference.
// ----------------------------------------------------------------------------
// Usage:
//   s_* is the coded pixel stream (valid/ready), one request per pixel with
//   red, green and blue codes and a frame_start flag that marks column 0.
//   m_* is the decoded pixel stream (valid/ready) with row_end on the last
//   pixel of each row.
//   Registers on the APB port: image_width at 0x0, delta_mode at 0x4.
//   Program them only while no pixel is in flight.
// Timing:
//   A pixel taken from s_* sits in the input register, is decoded into the
//   result register once that register is free or being read, and is offered
//   on m_* from then on. One pixel per cycle is sustained while m_ready is
//   high; the rate is set by the single decode step between the two registers,
//   which also updates the left-pixel state.
// Reset and stall:
//   aresetn (synchronous, active low) empties both registers, clears the
//   left pixel and column count, and sets width 1, independent mode.
//   When m_ready is low the result holds; the input register still fills,
//   so one more request is taken before s_ready drops.
// ----------------------------------------------------------------------------
module rgb_left_delta_decoder (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rgbld_pkg::ADDR_W-1:0]     paddr,
    input  logic [rgbld_pkg::DATA_W-1:0]     pwdata,
    output logic [rgbld_pkg::DATA_W-1:0]     prdata,
    output logic                             pready,
    // coded pixel stream
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [rgbld_pkg::PIX_W-1:0]      s_red_code,
    input  logic [rgbld_pkg::PIX_W-1:0]      s_green_code,
    input  logic [rgbld_pkg::PIX_W-1:0]      s_blue_code,
    input  logic                             s_frame_start,
    // decoded pixel stream
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rgbld_pkg::PIX_W-1:0]      m_red_out,
    output logic [rgbld_pkg::PIX_W-1:0]      m_green_out,
    output logic [rgbld_pkg::PIX_W-1:0]      m_blue_out,
    output logic                             m_row_end
);

    logic [rgbld_pkg::WIDTH_W-1:0] width_reg;
    logic                          mode_reg;
    logic                          cfg_write;
    rgbld_pkg::reg_index_t         cfg_index;

    rgbld_pkg::pixel_code_t        in_reg;
    logic                          in_valid_reg;
    rgbld_pkg::pixel_out_t         out_reg, out_next;
    logic                          out_valid_reg;

    logic [rgbld_pkg::PIX_W-1:0]   left_red_reg, left_green_reg, left_blue_reg;
    logic [rgbld_pkg::COL_W-1:0]   col_count_reg, col_count_next;
    logic [rgbld_pkg::COL_W-1:0]   col, col_last;
    logic [rgbld_pkg::PIX_W-1:0]   green_delta, red_delta, blue_delta, green_chg;
    logic                          advance;

    // configuration
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = rgbld_pkg::reg_index_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= rgbld_pkg::WIDTH_W'(1);
            mode_reg  <= 1'b0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                rgbld_pkg::REG_IMAGE_WIDTH: width_reg <= pwdata[rgbld_pkg::WIDTH_W-1:0];
                rgbld_pkg::REG_DELTA_MODE:  mode_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            rgbld_pkg::REG_IMAGE_WIDTH:
                prdata = {{(rgbld_pkg::DATA_W-rgbld_pkg::WIDTH_W){1'b0}}, width_reg};
            rgbld_pkg::REG_DELTA_MODE:
                prdata = {{(rgbld_pkg::DATA_W-1){1'b0}}, mode_reg};
            default:
                prdata = '0;
        endcase
    end

    // handshake: input register feeds result register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= '{red: s_red_code, green: s_green_code,
                        blue: s_blue_code, frame_start: s_frame_start};
        end
    end

    // decode
    assign col_last    = rgbld_pkg::last_column(width_reg);
    assign col         = in_reg.frame_start ? '0 : col_count_reg;
    assign green_delta = in_reg.green - rgbld_pkg::CODE_BIAS;
    assign red_delta   = in_reg.red - rgbld_pkg::CODE_BIAS;
    assign blue_delta  = in_reg.blue - rgbld_pkg::CODE_BIAS;
    // green change from the left pixel equals the unbiased green code
    assign green_chg   = mode_reg ? green_delta : '0;

    always_comb begin
        out_next.row_end = (col >= col_last);
        if (col == '0) begin
            out_next.red   = in_reg.red;
            out_next.green = in_reg.green;
            out_next.blue  = in_reg.blue;
        end else begin
            out_next.red   = left_red_reg + red_delta + green_chg;
            out_next.green = left_green_reg + green_delta;
            out_next.blue  = left_blue_reg + blue_delta + green_chg;
        end
        col_count_next = out_next.row_end ? '0 : col + rgbld_pkg::COL_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_red_reg   <= '0;
            left_green_reg <= '0;
            left_blue_reg  <= '0;
            col_count_reg  <= '0;
        end else if (advance) begin
            left_red_reg   <= out_next.red;
            left_green_reg <= out_next.green;
            left_blue_reg  <= out_next.blue;
            col_count_reg  <= col_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_red_out   = out_reg.red;
    assign m_green_out = out_reg.green;
    assign m_blue_out  = out_reg.blue;
    assign m_row_end   = out_reg.row_end;

    // assertions
    a_row_start_passthru: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_reg.frame_start || col_count_reg == '0)
        |=> m_red_out == $past(in_reg.red) && m_green_out == $past(in_reg.green)
            && m_blue_out == $past(in_reg.blue))
        else $error("row start pixel not passed through");

    a_row_end_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && out_next.row_end |=> col_count_reg == '0)
        else $error("column count did not wrap after row end");

    a_width_one_all_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && col_last == '0 |=> m_valid && m_row_end)
        else $error("width one pixel without row end");

    a_left_tracks_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> left_green_reg == m_green_out && left_red_reg == m_red_out
            && left_blue_reg == m_blue_out)
        else $error("left pixel differs from last result");

endmodule

// ===== bench/rgb_left_delta_decoder_test.sv =====
// ----------------------------------------------------------------------------
// rgb_left_delta_decoder_test
// Self-checking bench for the left-predicted RGB delta decoder. A scoreboard
// class keeps its own copy of the width, mode, left pixel and column count
// and works out every decoded pixel. Directed pixels cover code extremes,
// row starts, frame realignment, odd widths and mode changes; random phases
// then sweep register settings under bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module rgb_left_delta_decoder_test;

    localparam int CYCLE_LIMIT     = 100000;
    localparam int PHASES          = 12;
    localparam int PIXELS_PER_PHASE = 38;

    typedef enum int {
        READY_ALWAYS,
        READY_PATTERN,
        READY_RANDOM
    } ready_style_t;

    class pixel_decode_scoreboard;
        logic [rgbld_pkg::WIDTH_W-1:0] image_width;
        logic                          delta_mode;
        logic [rgbld_pkg::PIX_W-1:0]   left_red;
        logic [rgbld_pkg::PIX_W-1:0]   left_green;
        logic [rgbld_pkg::PIX_W-1:0]   left_blue;
        logic [rgbld_pkg::COL_W-1:0]   next_column;
        rgbld_pkg::pixel_out_t         expected_pixels[$];
        int                            mismatches;

        function new();
            image_width = rgbld_pkg::WIDTH_W'(1);
            delta_mode  = 1'b0;
            left_red    = '0;
            left_green  = '0;
            left_blue   = '0;
            next_column = '0;
            mismatches  = 0;
        endfunction

        function void write_register(rgbld_pkg::reg_index_t idx,
                                     logic [rgbld_pkg::DATA_W-1:0] value);
            if (idx == rgbld_pkg::REG_IMAGE_WIDTH) begin
                image_width = value[rgbld_pkg::WIDTH_W-1:0];
            end else begin
                delta_mode = value[0];
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void note_request(rgbld_pkg::pixel_code_t code);
            logic [rgbld_pkg::WIDTH_W-1:0] span;
            logic [rgbld_pkg::COL_W-1:0]   column;
            logic [rgbld_pkg::PIX_W-1:0]   green_step;
            rgbld_pkg::pixel_out_t         px;
            // zero acts as one, anything past the maximum is clamped
            if (image_width == '0) begin
                span = rgbld_pkg::WIDTH_W'(1);
            end else if (image_width > rgbld_pkg::MAX_WIDTH) begin
                span = rgbld_pkg::MAX_WIDTH;
            end else begin
                span = image_width;
            end
            column = code.frame_start ? '0 : next_column;
            if (column == '0) begin
                px.red   = code.red;
                px.green = code.green;
                px.blue  = code.blue;
            end else begin
                px.green   = code.green - rgbld_pkg::CODE_BIAS + left_green;
                green_step = delta_mode ? px.green - left_green : '0;
                px.red     = code.red - rgbld_pkg::CODE_BIAS + green_step + left_red;
                px.blue    = code.blue - rgbld_pkg::CODE_BIAS + green_step + left_blue;
            end
            // a column at or past the last one closes the row and wraps
            px.row_end  = (rgbld_pkg::WIDTH_W'(column) >= span - rgbld_pkg::WIDTH_W'(1));
            next_column = px.row_end ? '0 : column + rgbld_pkg::COL_W'(1);
            left_red    = px.red;
            left_green  = px.green;
            left_blue   = px.blue;
            expected_pixels.push_back(px);
        endfunction

        function void compare_field(string name, logic [rgbld_pkg::PIX_W-1:0] want,
                                    logic [rgbld_pkg::PIX_W-1:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_pixel(rgbld_pkg::pixel_out_t got);
            rgbld_pkg::pixel_out_t want;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                $display("%0t: pixel with no request pending, expected none, actual %0h",
                         $time, got);
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
            compare_field("row_end", rgbld_pkg::PIX_W'(want.row_end),
                          rgbld_pkg::PIX_W'(got.row_end));
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn       = 1'b0;
    logic                           psel          = 1'b0;
    logic                           penable       = 1'b0;
    logic                           pwrite        = 1'b0;
    logic [rgbld_pkg::ADDR_W-1:0]   paddr         = '0;
    logic [rgbld_pkg::DATA_W-1:0]   pwdata        = '0;
    logic [rgbld_pkg::DATA_W-1:0]   prdata;
    logic                           pready;
    logic                           s_valid       = 1'b0;
    logic                           s_ready;
    logic [rgbld_pkg::PIX_W-1:0]    s_red_code    = '0;
    logic [rgbld_pkg::PIX_W-1:0]    s_green_code  = '0;
    logic [rgbld_pkg::PIX_W-1:0]    s_blue_code   = '0;
    logic                           s_frame_start = 1'b0;
    logic                           m_valid;
    logic                           m_ready       = 1'b0;
    logic [rgbld_pkg::PIX_W-1:0]    m_red_out;
    logic [rgbld_pkg::PIX_W-1:0]    m_green_out;
    logic [rgbld_pkg::PIX_W-1:0]    m_blue_out;
    logic                           m_row_end;

    pixel_decode_scoreboard sb = new();

    ready_style_t ready_style   = READY_ALWAYS;
    logic [7:0]   stall_pattern = 8'hFF;
    int           gap_max       = 0;
    int           burst_left    = 0;
    int           cycle_count   = 0;

    int unsigned phase_width [0:PHASES-1] =
        '{1, 2, 5, 16384, 3, 0, 7, 32767, 4, 11, 16385, 6};

    rgb_left_delta_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_red_code    (s_red_code),
        .s_green_code  (s_green_code),
        .s_blue_code   (s_blue_code),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_out     (m_red_out),
        .m_green_out   (m_green_out),
        .m_blue_out    (m_blue_out),
        .m_row_end     (m_row_end)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // receiver: check accepted pixels, then pick next ready
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready) begin
            sb.check_pixel({m_red_out, m_green_out, m_blue_out, m_row_end});
        end
        case (ready_style)
            READY_ALWAYS:  m_ready <= 1'b1;
            READY_PATTERN: m_ready <= stall_pattern[cycle_count[2:0]];
            default:       m_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge aclk) begin
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [rgbld_pkg::PIX_W-1:0] random_code();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            return rgbld_pkg::PIX_W'($urandom_range(0, 255));
        end else if (pick < 8) begin
            // small deltas around the bias
            return rgbld_pkg::CODE_BIAS + rgbld_pkg::PIX_W'($urandom_range(0, 8))
                   - rgbld_pkg::PIX_W'(4);
        end
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            default: return 8'h81;
        endcase
    endfunction

    function automatic rgbld_pkg::pixel_code_t random_pixel();
        rgbld_pkg::pixel_code_t p;
        p.red         = random_code();
        p.green       = random_code();
        p.blue        = random_code();
        p.frame_start = ($urandom_range(0, 19) == 0);
        return p;
    endfunction

    // holds the request until taken, then maybe opens a gap
    task automatic send_pixel(input rgbld_pkg::pixel_code_t p);
        s_valid       <= 1'b1;
        s_red_code    <= p.red;
        s_green_code  <= p.green;
        s_blue_code   <= p.blue;
        s_frame_start <= p.frame_start;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(p);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gap_max != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic program_reg(input rgbld_pkg::reg_index_t idx,
                               input logic [rgbld_pkg::DATA_W-1:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_register(idx, value);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // width 1 after reset: every pixel is a row of its own
        send_pixel({8'h00, 8'h00, 8'h00, 1'b0});
        send_pixel({8'hFF, 8'hFF, 8'hFF, 1'b1});

        // zero width behaves as one
        program_reg(rgbld_pkg::REG_IMAGE_WIDTH, 32'd0);
        send_pixel({8'h80, 8'h7F, 8'h81, 1'b0});

        // independent deltas, largest steps both ways, realign mid-row
        program_reg(rgbld_pkg::REG_IMAGE_WIDTH, 32'd4);
        send_pixel({8'h10, 8'h20, 8'h30, 1'b1});
        send_pixel({8'hFF, 8'hFF, 8'hFF, 1'b0});
        send_pixel({8'h00, 8'h00, 8'h00, 1'b0});
        send_pixel({8'h80, 8'h80, 8'h80, 1'b0});
        send_pixel({8'h05, 8'h06, 8'h07, 1'b0});
        send_pixel({8'h81, 8'h7F, 8'h80, 1'b0});
        send_pixel({8'hAA, 8'hBB, 8'hCC, 1'b1});
        send_pixel({8'h90, 8'h70, 8'h80, 1'b0});

        // green reference switched on in the middle of a row
        program_reg(rgbld_pkg::REG_DELTA_MODE, 32'd1);
        send_pixel({8'h90, 8'hA0, 8'h70, 1'b0});
        send_pixel({8'h80, 8'hFF, 8'h80, 1'b0});
        send_pixel({8'h12, 8'h34, 8'h56, 1'b0});
        send_pixel({8'h80, 8'h00, 8'h80, 1'b0});
        send_pixel({8'hFF, 8'h90, 8'h00, 1'b0});

        // width beyond the maximum is clamped
        program_reg(rgbld_pkg::REG_IMAGE_WIDTH, 32'h0000_7FFF);
        send_pixel({8'h01, 8'h02, 8'h03, 1'b1});
        send_pixel({8'h7F, 8'h81, 8'hFF, 1'b0});

        // width lowered while the column is already past the new end
        program_reg(rgbld_pkg::REG_IMAGE_WIDTH, 32'd2);
        send_pixel({8'h80, 8'h80, 8'h80, 1'b0});
        send_pixel({8'h33, 8'h44, 8'h55, 1'b0});

        for (int phase = 0; phase < PHASES; phase++) begin
            program_reg(rgbld_pkg::REG_IMAGE_WIDTH,
                        rgbld_pkg::DATA_W'(phase_width[phase]));
            program_reg(rgbld_pkg::REG_DELTA_MODE, rgbld_pkg::DATA_W'(phase % 2));
            ready_style   <= ready_style_t'(phase % 3);
            stall_pattern <= 8'($urandom_range(1, 254));
            gap_max        = (phase % 4) * 3;
            for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
                send_pixel(random_pixel());
            end
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
